// File: design/mlfs_pkg.sv
// shared constants, codes and controller/datapath handshake types of the feedback-queue scheduler
package mlfs_pkg;

  localparam int SLOT_COUNT_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS       = 16;
  localparam int NUM_LEVELS      = 4;
  localparam int LEVEL_BITS      = 2;
  localparam int WORK_BITS       = 10;
  localparam int TMO_BITS        = 10;
  localparam int ID_OUT_BITS     = 4;

  localparam logic [TMO_BITS-1:0] TIMEOUT_RESET = 10'd20;

  typedef enum logic [2:0] {
    EV_LOADED    = 3'd0,
    EV_REJECTED  = 3'd1,
    EV_IDLE      = 3'd2,
    EV_TIMEOUT   = 3'd3,
    EV_FINISHED  = 3'd4,
    EV_SUSPENDED = 3'd5,
    EV_STARTED   = 3'd6,
    EV_RUNNING   = 3'd7
  } event_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_EV,
    OP_RUN_RD,
    OP_RUN_EV,
    OP_SEL_INIT,
    OP_FIFO_RD,
    OP_POP,
    OP_CHECK,
    OP_LVL_NEXT,
    OP_EXE_RD,
    OP_EXE_EV,
    OP_IDLE_EV
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_done;
    logic out_free;
    logic run_valid;
    logic fill_nz;
    logic lvl_last;
  } dp_status_t;

endpackage

// File: design/mlfs_ctrl.sv
// sequencer that walks the scheduler datapath through load and tick operations
module mlfs_ctrl
  import mlfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD,
    ST_SCAN_INIT,
    ST_SCAN_CHK,
    ST_SCAN_EV,
    ST_RUN_RD,
    ST_RUN_EV,
    ST_SEL_INIT,
    ST_SEL_CHK,
    ST_POP,
    ST_CHECK,
    ST_EXE_RD,
    ST_EXE_EV,
    ST_IDLE_EV
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: state_nxt = status.is_tick ? ST_SCAN_INIT : ST_LOAD;
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN_INIT: begin
        cmd.op    = OP_SCAN_INIT;
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (status.scan_done) begin
          state_nxt = ST_RUN_RD;
        end else begin
          cmd.op    = OP_SCAN_RD;
          state_nxt = ST_SCAN_EV;
        end
      end
      ST_SCAN_EV: begin
        if (status.out_free) begin
          cmd.op    = OP_SCAN_EV;
          state_nxt = ST_SCAN_CHK;
        end
      end
      ST_RUN_RD: begin
        if (status.run_valid) begin
          cmd.op    = OP_RUN_RD;
          state_nxt = ST_RUN_EV;
        end else begin
          state_nxt = ST_SEL_INIT;
        end
      end
      ST_RUN_EV: begin
        if (status.out_free) begin
          cmd.op    = OP_RUN_EV;
          state_nxt = ST_SEL_INIT;
        end
      end
      ST_SEL_INIT: begin
        cmd.op    = OP_SEL_INIT;
        state_nxt = ST_SEL_CHK;
      end
      ST_SEL_CHK: begin
        priority if (status.run_valid) begin
          state_nxt = ST_EXE_RD;
        end else if (status.fill_nz) begin
          cmd.op    = OP_FIFO_RD;
          state_nxt = ST_POP;
        end else if (status.lvl_last) begin
          state_nxt = ST_EXE_RD;
        end else begin
          cmd.op = OP_LVL_NEXT;
        end
      end
      ST_POP: begin
        cmd.op    = OP_POP;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.op    = OP_CHECK;
        state_nxt = ST_SEL_CHK;
      end
      ST_EXE_RD: begin
        if (status.run_valid) begin
          cmd.op    = OP_EXE_RD;
          state_nxt = ST_EXE_EV;
        end else begin
          state_nxt = ST_IDLE_EV;
        end
      end
      ST_EXE_EV: begin
        if (status.out_free) begin
          cmd.op    = OP_EXE_EV;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE_EV: begin
        if (status.out_free) begin
          cmd.op    = OP_IDLE_EV;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/mlfs_dp.sv
// scheduler datapath: task table, level fifos, counters and result register
module mlfs_dp
  import mlfs_pkg::*;
#(
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic                   in_command,
  input  logic [15:0]            in_arrival_time,
  input  logic [1:0]             in_start_level,
  input  logic [9:0]             in_burst_ticks,
  input  logic                   cfg_valid,
  input  logic [TMO_BITS-1:0]    cfg_timeout_ticks,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_event_res,
  output logic [ID_OUT_BITS-1:0] out_task_id,
  output logic [15:0]            out_at_time,
  output logic [1:0]             out_level,
  output logic [9:0]             out_remaining_ticks,
  output logic                   out_last,
  output logic                   out_all_done
);

  localparam int IW  = $clog2(SLOT_COUNT);
  localparam int CW  = $clog2(SLOT_COUNT + 1);
  localparam int HW  = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int FD  = NUM_LEVELS * QUEUE_DEPTH;
  localparam int FAW = $clog2(FD);

  typedef struct packed {
    logic [TIME_BITS-1:0]  arrival;
    logic [LEVEL_BITS-1:0] level;
    logic [WORK_BITS-1:0]  burst;
    logic [WORK_BITS-1:0]  left;
    logic [TIME_BITS-1:0]  last_run;
  } task_rec_t;

  task_rec_t       task_mem [SLOT_COUNT];
  logic [IW-1:0]   fifo_mem [FD];

  // control state
  logic [TMO_BITS-1:0]   timeout_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         act_r, act_nxt;
  logic [TIME_BITS-1:0]  now_r, now_nxt;
  logic                  run_valid_r, run_valid_nxt;
  logic [IW-1:0]         run_id_r, run_id_nxt;
  logic [HW-1:0]         head_r [NUM_LEVELS];
  logic [HW-1:0]         head_nxt [NUM_LEVELS];
  logic [FW-1:0]         fill_r [NUM_LEVELS];
  logic [FW-1:0]         fill_nxt [NUM_LEVELS];
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [LEVEL_BITS-1:0] lvl_r, lvl_nxt;
  logic                  picked_r, picked_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // payload
  logic                  cmd_tick_r;
  logic [TIME_BITS-1:0]  in_arr_r;
  logic [LEVEL_BITS-1:0] in_lvl_r;
  logic [WORK_BITS-1:0]  in_burst_r;
  task_rec_t             rd_r;
  logic [IW-1:0]         fifo_rd_r;
  logic [IW-1:0]         cand_r;
  event_t                out_ev_r;
  logic [IW-1:0]         out_id_r;
  logic [TIME_BITS-1:0]  out_time_r;
  logic [LEVEL_BITS-1:0] out_lvl_r;
  logic [WORK_BITS-1:0]  out_rem_r;
  logic                  out_last_r;
  logic                  out_done_r;

  // memory ports
  logic                  tm_we, tm_re;
  logic [IW-1:0]         tm_waddr, tm_raddr;
  task_rec_t             tm_wdata;
  logic                  fifo_we, fifo_re;
  logic [FAW-1:0]        fifo_waddr, fifo_raddr;
  logic [IW-1:0]         fifo_wdata;

  // push request and event request
  logic                  push_en;
  logic [LEVEL_BITS-1:0] push_lvl;
  logic [IW-1:0]         push_id;
  logic [FW:0]           push_sum;
  logic [HW-1:0]         push_pos;
  logic                  em_en;
  event_t                em_ev;
  logic [IW-1:0]         em_id;
  logic [LEVEL_BITS-1:0] em_lvl;
  logic [WORK_BITS-1:0]  em_rem;
  logic                  em_last;

  logic [TIME_BITS-1:0]  idle_time;
  logic                  kill;
  logic [LEVEL_BITS-1:0] demoted;
  logic [WORK_BITS-1:0]  left_dec;

  assign idle_time = now_r - rd_r.last_run;
  assign kill      = (rd_r.left != '0) && (rd_r.arrival <= now_r)
                     && (idle_time >= TIME_BITS'(timeout_r));
  assign demoted   = (rd_r.level == LEVEL_BITS'(NUM_LEVELS - 1)) ? rd_r.level
                     : rd_r.level + 1'b1;
  assign left_dec  = (rd_r.left != '0) ? rd_r.left - 1'b1 : rd_r.left;

  always_comb begin
    count_nxt     = count_r;
    act_nxt       = act_r;
    now_nxt       = now_r;
    run_valid_nxt = run_valid_r;
    run_id_nxt    = run_id_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    lvl_nxt       = lvl_r;
    picked_nxt    = picked_r;
    tm_we         = 1'b0;
    tm_re         = 1'b0;
    tm_waddr      = '0;
    tm_raddr      = '0;
    tm_wdata      = rd_r;
    fifo_re       = 1'b0;
    fifo_raddr    = FAW'(int'(lvl_r) * QUEUE_DEPTH + int'(head_r[lvl_r]));
    push_en       = 1'b0;
    push_lvl      = rd_r.level;
    push_id       = '0;
    em_en         = 1'b0;
    em_ev         = EV_IDLE;
    em_id         = '0;
    em_lvl        = '0;
    em_rem        = '0;
    em_last       = 1'b0;

    unique case (cmd.op)
      OP_LOAD: begin
        em_en   = 1'b1;
        em_last = 1'b1;
        if (count_r >= CW'(SLOT_COUNT)) begin
          em_ev = EV_REJECTED;
        end else begin
          tm_we             = 1'b1;
          tm_waddr          = count_r[IW-1:0];
          tm_wdata.arrival  = in_arr_r;
          tm_wdata.level    = in_lvl_r;
          tm_wdata.burst    = in_burst_r;
          tm_wdata.left     = in_burst_r;
          tm_wdata.last_run = in_arr_r;
          count_nxt         = count_r + 1'b1;
          if (in_burst_r != '0) act_nxt = act_r + 1'b1;
          em_ev  = EV_LOADED;
          em_id  = count_r[IW-1:0];
          em_lvl = in_lvl_r;
          em_rem = in_burst_r;
        end
      end
      OP_SCAN_INIT: idx_nxt = '0;
      OP_SCAN_RD: begin
        tm_re    = 1'b1;
        tm_raddr = idx_r[IW-1:0];
      end
      OP_SCAN_EV: begin
        idx_nxt = idx_r + 1'b1;
        if (kill) begin
          tm_we         = 1'b1;
          tm_waddr      = idx_r[IW-1:0];
          tm_wdata.left = '0;
          if (act_r != '0) act_nxt = act_r - 1'b1;
          if (run_valid_r && run_id_r == idx_r[IW-1:0]) run_valid_nxt = 1'b0;
          em_en  = 1'b1;
          em_ev  = EV_TIMEOUT;
          em_id  = idx_r[IW-1:0];
          em_lvl = rd_r.level;
        end else if (rd_r.arrival == now_r && rd_r.left != '0) begin
          push_en  = 1'b1;
          push_lvl = rd_r.level;
          push_id  = idx_r[IW-1:0];
        end
      end
      OP_RUN_RD, OP_EXE_RD: begin
        tm_re    = 1'b1;
        tm_raddr = run_id_r;
      end
      OP_RUN_EV: begin
        if (rd_r.left == '0) begin
          if (act_r != '0) act_nxt = act_r - 1'b1;
          run_valid_nxt = 1'b0;
          em_en  = 1'b1;
          em_ev  = EV_FINISHED;
          em_id  = run_id_r;
          em_lvl = rd_r.level;
        end else if (rd_r.level != '0) begin
          // demote one level (saturating at the last level) and requeue
          tm_we          = 1'b1;
          tm_waddr       = run_id_r;
          tm_wdata.level = demoted;
          push_en        = 1'b1;
          push_lvl       = demoted;
          push_id        = run_id_r;
          run_valid_nxt  = 1'b0;
          em_en  = 1'b1;
          em_ev  = EV_SUSPENDED;
          em_id  = run_id_r;
          em_lvl = demoted;
          em_rem = rd_r.left;
        end
      end
      OP_SEL_INIT: begin
        lvl_nxt    = '0;
        picked_nxt = 1'b0;
      end
      OP_FIFO_RD: fifo_re = 1'b1;
      OP_POP: begin
        tm_re    = 1'b1;
        tm_raddr = fifo_rd_r;
        head_nxt[lvl_r] = (head_r[lvl_r] == HW'(QUEUE_DEPTH - 1)) ? '0
                          : head_r[lvl_r] + 1'b1;
        fill_nxt[lvl_r] = fill_r[lvl_r] - 1'b1;
      end
      OP_CHECK: begin
        if (rd_r.left != '0) begin
          run_valid_nxt = 1'b1;
          run_id_nxt    = cand_r;
          picked_nxt    = 1'b1;
        end
      end
      OP_LVL_NEXT: lvl_nxt = lvl_r + 1'b1;
      OP_EXE_EV: begin
        tm_we             = 1'b1;
        tm_waddr          = run_id_r;
        tm_wdata.last_run = now_r;
        tm_wdata.left     = left_dec;
        now_nxt           = now_r + 1'b1;
        em_en   = 1'b1;
        em_last = 1'b1;
        em_ev   = (picked_r && rd_r.burst == rd_r.left) ? EV_STARTED : EV_RUNNING;
        em_id   = run_id_r;
        em_lvl  = rd_r.level;
        em_rem  = left_dec;
      end
      OP_IDLE_EV: begin
        now_nxt = now_r + 1'b1;
        em_en   = 1'b1;
        em_last = 1'b1;
        em_ev   = EV_IDLE;
      end
      default: ;
    endcase

    // level fifo push, dropped when full
    push_sum   = (FW+1)'(head_r[push_lvl]) + (FW+1)'(fill_r[push_lvl]);
    push_pos   = (push_sum >= (FW+1)'(QUEUE_DEPTH)) ? HW'(push_sum - (FW+1)'(QUEUE_DEPTH))
                 : HW'(push_sum);
    fifo_we    = 1'b0;
    fifo_waddr = FAW'(int'(push_lvl) * QUEUE_DEPTH + int'(push_pos));
    fifo_wdata = push_id;
    if (push_en && fill_r[push_lvl] < FW'(QUEUE_DEPTH)) begin
      fifo_we            = 1'b1;
      fill_nxt[push_lvl] = fill_r[push_lvl] + 1'b1;
    end

    out_valid_nxt = out_valid_r;
    if (em_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tm_we) task_mem[tm_waddr] <= tm_wdata;
    if (tm_re) rd_r <= task_mem[tm_raddr];
    if (fifo_we) fifo_mem[fifo_waddr] <= fifo_wdata;
    if (fifo_re) fifo_rd_r <= fifo_mem[fifo_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RESET;
      count_r     <= '0;
      act_r       <= '0;
      now_r       <= '0;
      run_valid_r <= 1'b0;
      run_id_r    <= '0;
      idx_r       <= '0;
      lvl_r       <= '0;
      picked_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_r[l] <= '0;
        fill_r[l] <= '0;
      end
    end else begin
      if (cfg_valid) timeout_r <= cfg_timeout_ticks;
      count_r     <= count_nxt;
      act_r       <= act_nxt;
      now_r       <= now_nxt;
      run_valid_r <= run_valid_nxt;
      run_id_r    <= run_id_nxt;
      idx_r       <= idx_nxt;
      lvl_r       <= lvl_nxt;
      picked_r    <= picked_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE) begin
      cmd_tick_r <= in_command;
      in_arr_r   <= TIME_BITS'(in_arrival_time);
      in_lvl_r   <= in_start_level;
      in_burst_r <= in_burst_ticks;
    end
    if (cmd.op == OP_POP) cand_r <= fifo_rd_r;
    if (em_en) begin
      out_ev_r   <= em_ev;
      out_id_r   <= em_id;
      out_time_r <= now_r;
      out_lvl_r  <= em_lvl;
      out_rem_r  <= em_rem;
      out_last_r <= em_last;
      out_done_r <= (act_nxt == '0);
    end
  end

  assign status.is_tick   = cmd_tick_r;
  assign status.scan_done = (idx_r == count_r);
  assign status.out_free  = !out_valid_r || out_ready;
  assign status.run_valid = run_valid_r;
  assign status.fill_nz   = (fill_r[lvl_r] != '0);
  assign status.lvl_last  = (lvl_r == LEVEL_BITS'(NUM_LEVELS - 1));

  assign out_valid           = out_valid_r;
  assign out_event_res       = out_ev_r;
  assign out_task_id         = ID_OUT_BITS'(out_id_r);
  assign out_at_time         = 16'(out_time_r);
  assign out_level           = out_lvl_r;
  assign out_remaining_ticks = out_rem_r;
  assign out_last            = out_last_r;
  assign out_all_done        = out_done_r;

endmodule

// File: design/multilevel_feedback_scheduler.sv
// top level of the four-level feedback-queue scheduler
// A load word stores one task in the next slot, or is rejected when the table is full, and
// answers with one result word. A tick word walks every loaded slot through the task table
// (timeout check and arrival queuing), checks the running task, pops the level fifos until
// a live task turns up, then runs it for one unit, or reports an idle tick if none is found.
// Each result word waits in an output register; the word that closes an input has last set.
// The timeout register is written through the cfg port, which is always ready.
module multilevel_feedback_scheduler
  import mlfs_pkg::*;
#(
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_command,
  input  logic [15:0]            in_arrival_time,
  input  logic [1:0]             in_start_level,
  input  logic [9:0]             in_burst_ticks,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [TMO_BITS-1:0]    cfg_timeout_ticks,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_event_res,
  output logic [ID_OUT_BITS-1:0] out_task_id,
  output logic [15:0]            out_at_time,
  output logic [1:0]             out_level,
  output logic [9:0]             out_remaining_ticks,
  output logic                   out_last,
  output logic                   out_all_done
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  mlfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mlfs_dp #(
    .SLOT_COUNT  (SLOT_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_command          (in_command),
    .in_arrival_time     (in_arrival_time),
    .in_start_level      (in_start_level),
    .in_burst_ticks      (in_burst_ticks),
    .cfg_valid           (cfg_valid),
    .cfg_timeout_ticks   (cfg_timeout_ticks),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_res       (out_event_res),
    .out_task_id         (out_task_id),
    .out_at_time         (out_at_time),
    .out_level           (out_level),
    .out_remaining_ticks (out_remaining_ticks),
    .out_last            (out_last),
    .out_all_done        (out_all_done)
  );

endmodule

// File: verif/testbench.sv
// self-checking testbench of the feedback-queue scheduler
module testbench;
  import mlfs_pkg::*;

  localparam int NSLOT = 16;
  localparam int QD    = 16;

  typedef struct packed {
    logic       command;
    logic [15:0] arrival;
    logic [1:0] lvl;
    logic [9:0] burst;
  } sched_word_t;

  typedef struct packed {
    event_t      ev;
    logic [3:0]  id;
    logic [15:0] at;
    logic [1:0]  lvl;
    logic [9:0]  rem;
    logic        last;
    logic        done;
  } sched_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = 1'b0;
  logic [15:0] in_arrival_time = '0;
  logic [1:0] in_start_level = '0;
  logic [9:0] in_burst_ticks = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TMO_BITS-1:0] cfg_timeout_ticks = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_event_res;
  logic [3:0] out_task_id;
  logic [15:0] out_at_time;
  logic [1:0] out_level;
  logic [9:0] out_remaining_ticks;
  logic out_last;
  logic out_all_done;

  multilevel_feedback_scheduler u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [9:0]  tmo;
  logic [15:0] t_arr [NSLOT];
  logic [1:0]  t_lvl [NSLOT];
  logic [9:0]  t_burst [NSLOT];
  logic [9:0]  t_left [NSLOT];
  logic [15:0] t_last [NSLOT];
  int          n_loaded, n_active;
  logic [15:0] clock_now;
  logic        run_v;
  logic [3:0]  run_id;
  logic [3:0]  lq [4][QD];
  int          lq_head [4];
  int          lq_fill [4];

  sched_word_t  pending_words[$];
  sched_event_t expected_events[$];
  int errors = 0;
  int send_idle = 7, recv_idle = 57;
  bit hold_off = 1'b0;
  bit in_ready_seen = 1'b0;

  task automatic add_event(event_t ev, int id, int lvl, int rem);
    sched_event_t e;
    e.ev = ev; e.id = 4'(id); e.at = clock_now; e.lvl = 2'(lvl); e.rem = 10'(rem);
    e.last = 1'b0; e.done = (n_active == 0);
    expected_events.push_back(e);
  endtask

  task automatic lq_push(int l, int id);
    if (lq_fill[l] < QD) begin
      lq[l][(lq_head[l] + lq_fill[l]) % QD] = 4'(id);
      lq_fill[l]++;
    end
  endtask

  task automatic predict_word(sched_word_t w);
    int i, l, id;
    bit fresh;
    if (!w.command) begin
      if (n_loaded >= NSLOT) add_event(EV_REJECTED, 0, 0, 0);
      else begin
        i = n_loaded;
        t_arr[i] = w.arrival; t_lvl[i] = w.lvl; t_burst[i] = w.burst;
        t_left[i] = w.burst; t_last[i] = w.arrival;
        n_loaded++;
        if (w.burst != 0) n_active++;
        add_event(EV_LOADED, i, w.lvl, w.burst);
      end
    end else begin
      for (i = 0; i < n_loaded; i++)
        if (t_left[i] != 0 && t_arr[i] <= clock_now &&
            16'(clock_now - t_last[i]) >= tmo) begin
          t_left[i] = 0;
          if (n_active > 0) n_active--;
          if (run_v && run_id == i) run_v = 1'b0;
          add_event(EV_TIMEOUT, i, t_lvl[i], 0);
        end
      for (i = 0; i < n_loaded; i++)
        if (t_arr[i] == clock_now && t_left[i] != 0) lq_push(t_lvl[i], i);
      if (run_v) begin
        i = run_id;
        if (t_left[i] == 0) begin
          if (n_active > 0) n_active--;
          run_v = 1'b0;
          add_event(EV_FINISHED, i, t_lvl[i], 0);
        end else if (t_lvl[i] > 0) begin
          if (t_lvl[i] < 3) t_lvl[i]++;
          lq_push(t_lvl[i], i);
          run_v = 1'b0;
          add_event(EV_SUSPENDED, i, t_lvl[i], t_left[i]);
        end
      end
      fresh = 1'b0;
      if (!run_v) begin
        for (l = 0; l < 4 && !run_v; l++)
          while (!run_v && lq_fill[l] > 0) begin
            id = lq[l][lq_head[l]];
            lq_head[l] = (lq_head[l] + 1) % QD;
            lq_fill[l]--;
            if (t_left[id] != 0) begin
              run_v = 1'b1; run_id = 4'(id);
            end
          end
        if (run_v && t_burst[run_id] == t_left[run_id]) fresh = 1'b1;
      end
      if (run_v) begin
        i = run_id;
        t_last[i] = clock_now;
        if (t_left[i] != 0) t_left[i]--;
        add_event(fresh ? EV_STARTED : EV_RUNNING, i, t_lvl[i], t_left[i]);
      end else add_event(EV_IDLE, 0, 0, 0);
      clock_now++;
    end
    expected_events[$].last = 1'b1;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
          sched_word_t w;
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          in_command <= w.command; in_arrival_time <= w.arrival;
          in_start_level <= w.lvl; in_burst_ticks <= w.burst;
          predict_word(w);
        end else in_valid <= 1'b0;
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  // capture acceptance at the rising edge for the driver
  always @(posedge clk) in_ready_seen <= in_valid && in_ready;

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch("unexpected word event", out_event_res, 0);
      end else begin
        sched_event_t e;
        e = expected_events.pop_front();
        if (out_event_res != e.ev) report_mismatch("event", out_event_res, e.ev);
        if (out_task_id != e.id) report_mismatch("task_id", out_task_id, e.id);
        if (out_at_time != e.at) report_mismatch("at_time", out_at_time, e.at);
        if (out_level != e.lvl) report_mismatch("level", out_level, e.lvl);
        if (out_remaining_ticks != e.rem)
          report_mismatch("remaining", out_remaining_ticks, e.rem);
        if (out_last != e.last) report_mismatch("last", out_last, e.last);
        if (out_all_done != e.done) report_mismatch("all_done", out_all_done, e.done);
      end
    end
  end

  function automatic sched_word_t load_word(int arr, int lvl, int burst);
    sched_word_t w;
    w.command = 1'b0; w.arrival = 16'(arr); w.lvl = 2'(lvl); w.burst = 10'(burst);
    return w;
  endfunction

  function automatic sched_word_t tick_word();
    sched_word_t w;
    w = '0; w.command = 1'b1;
    w.arrival = 16'($urandom); w.lvl = 2'($urandom); w.burst = 10'($urandom);
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_events.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_timeout(int v);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_timeout_ticks <= TMO_BITS'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tmo = 10'(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // queues a random mix of load and tick words
  task automatic random_phase(int nitems);
    int k;
    for (k = 0; k < nitems; k++) begin
      if ($urandom_range(99) < 20)
        pending_words.push_back(load_word(
          ($urandom_range(3) == 0) ? $urandom : clock_now + $urandom_range(nitems),
          $urandom, ($urandom_range(9) == 0) ? $urandom : $urandom_range(6)));
      else pending_words.push_back(tick_word());
    end
  endtask

  initial begin
    int k;
    tmo = TIMEOUT_RESET;
    n_loaded = 0; n_active = 0; clock_now = 0; run_v = 0; run_id = 0;
    for (k = 0; k < 4; k++) begin lq_head[k] = 0; lq_fill[k] = 0; end
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // directed: every level, zero and full burst, an idle tick, far arrival
    pending_words.push_back(tick_word());
    pending_words.push_back(load_word(1, 0, 2));
    pending_words.push_back(load_word(1, 1, 3));
    pending_words.push_back(load_word(2, 2, 1));
    pending_words.push_back(load_word(2, 3, 0));
    pending_words.push_back(load_word(3, 3, 1023));
    pending_words.push_back(load_word(16'hffff, 1, 5));
    for (k = 0; k < 14; k++) pending_words.push_back(tick_word());
    wait_drained();
    write_timeout(3);
    random_phase(40);
    wait_drained();
    send_idle = 57; recv_idle = 7;
    write_timeout(1023);
    random_phase(30);
    // long receiver hold-off so the block backs up
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    wait_drained();
    send_idle = 0; recv_idle = 0;
    write_timeout(0);
    random_phase(25);
    wait_drained();
    write_timeout(1);
    random_phase(15);
    pending_words.push_back(load_word(0, 0, 1));
    pending_words.push_back(load_word(0, 0, 1));
    wait_drained();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
